// ----- sv/mcr_pkg.sv -----
package mcr_pkg;

    // coordinate width of the centre and radius fields
    localparam int COORD_BITS  = 12;
    localparam int OFF_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int PIX_BITS    = COORD_BITS + 2;
    localparam int CANVAS_BITS = COORD_BITS + 1;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8;
    localparam int M_USER_BITS = 2;

    // register port
    localparam int ADDR_BITS = 3;
    localparam int APB_BITS  = 32;
    localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = CANVAS_BITS'(4096);

    // register indexes, taken from paddr[2]
    localparam logic REG_CANVAS_W = 1'b0;
    localparam logic REG_CANVAS_H = 1'b1;

    // item kinds carried in tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // points of one step item
    localparam int PTS_PER_STEP = 8;
    localparam int IDX_BITS     = $clog2(PTS_PER_STEP);

    // one step item's worth of results, handed to the emitter
    typedef struct packed {
        logic                       done;
        logic [COORD_BITS-1:0]      cx;
        logic [COORD_BITS-1:0]      cy;
        logic signed [OFF_BITS-1:0] a;
        logic signed [OFF_BITS-1:0] b;
    } t_point_set;

endpackage

// ----- sv/mcr_emitter.sv -----
module mcr_emitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  mcr_pkg::t_point_set               i_set,
    output logic                              o_ready,
    input  logic [mcr_pkg::CANVAS_BITS-1:0]   i_canvas_w,
    input  logic [mcr_pkg::CANVAS_BITS-1:0]   i_canvas_h,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic signed [mcr_pkg::PIX_BITS-1:0] o_px,
    output logic signed [mcr_pkg::PIX_BITS-1:0] o_py,
    output logic                              o_visible,
    output logic                              o_done,
    output logic                              o_last
);
    import mcr_pkg::*;

    localparam int WIDE = PIX_BITS + 1;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(PTS_PER_STEP - 1);

    t_point_set                 r_set;
    logic                       r_set_vld;
    logic [IDX_BITS-1:0]        r_idx;
    logic                       r_out_vld;
    logic signed [PIX_BITS-1:0] r_px;
    logic signed [PIX_BITS-1:0] r_py;
    logic                       r_visible;
    logic                       r_done;
    logic                       r_last;

    logic                       w_out_load;
    logic                       w_set_last;
    logic                       w_swap;
    logic                       w_neg_x;
    logic                       w_neg_y;
    logic signed [WIDE-1:0]     w_cx;
    logic signed [WIDE-1:0]     w_cy;
    logic signed [WIDE-1:0]     w_dx;
    logic signed [WIDE-1:0]     w_dy;
    logic signed [WIDE-1:0]     w_sx;
    logic signed [WIDE-1:0]     w_sy;
    logic signed [PIX_BITS-1:0] n_px;
    logic signed [PIX_BITS-1:0] n_py;
    logic                       n_visible;

    // output register takes the next point when empty or being drained
    assign w_out_load = r_set_vld && (!r_out_vld || i_rdy);
    assign w_set_last = r_set.done || (r_idx == IDX_LAST);
    assign o_ready    = !r_set_vld || (w_out_load && w_set_last);

    // octant selection for the current point
    always_comb begin
        w_swap  = 1'b0;
        w_neg_x = 1'b0;
        w_neg_y = 1'b0;
        case (r_idx)
            3'd0: begin w_swap = 1'b0; w_neg_x = 1'b0; w_neg_y = 1'b0; end
            3'd1: begin w_swap = 1'b1; w_neg_x = 1'b0; w_neg_y = 1'b0; end
            3'd2: begin w_swap = 1'b1; w_neg_x = 1'b1; w_neg_y = 1'b0; end
            3'd3: begin w_swap = 1'b0; w_neg_x = 1'b1; w_neg_y = 1'b0; end
            3'd4: begin w_swap = 1'b0; w_neg_x = 1'b1; w_neg_y = 1'b1; end
            3'd5: begin w_swap = 1'b1; w_neg_x = 1'b1; w_neg_y = 1'b1; end
            3'd6: begin w_swap = 1'b1; w_neg_x = 1'b0; w_neg_y = 1'b1; end
            3'd7: begin w_swap = 1'b0; w_neg_x = 1'b0; w_neg_y = 1'b1; end
            default: begin w_swap = 1'b0; w_neg_x = 1'b0; w_neg_y = 1'b0; end
        endcase
    end

    // point coordinates and canvas clipping
    always_comb begin
        w_cx = {{(WIDE-COORD_BITS){1'b0}}, r_set.cx};
        w_cy = {{(WIDE-COORD_BITS){1'b0}}, r_set.cy};
        w_dx = w_swap ? {{(WIDE-OFF_BITS){r_set.b[OFF_BITS-1]}}, r_set.b}
                      : {{(WIDE-OFF_BITS){r_set.a[OFF_BITS-1]}}, r_set.a};
        w_dy = w_swap ? {{(WIDE-OFF_BITS){r_set.a[OFF_BITS-1]}}, r_set.a}
                      : {{(WIDE-OFF_BITS){r_set.b[OFF_BITS-1]}}, r_set.b};
        w_sx = w_neg_x ? (w_cx - w_dx) : (w_cx + w_dx);
        w_sy = w_neg_y ? (w_cy - w_dy) : (w_cy + w_dy);
        if (r_set.done) begin
            n_px      = '0;
            n_py      = '0;
            n_visible = 1'b0;
        end else begin
            n_px      = w_sx[PIX_BITS-1:0];
            n_py      = w_sy[PIX_BITS-1:0];
            n_visible = !n_px[PIX_BITS-1] && !n_py[PIX_BITS-1]
                        && (n_px[CANVAS_BITS-1:0] < i_canvas_w)
                        && (n_py[CANVAS_BITS-1:0] < i_canvas_h);
        end
    end

    // point set register and its index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_vld <= 1'b0;
            r_idx     <= '0;
        end else if (i_load) begin
            r_set_vld <= 1'b1;
            r_idx     <= '0;
        end else if (w_out_load && w_set_last) begin
            r_set_vld <= 1'b0;
        end else if (w_out_load) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_px      <= n_px;
            r_py      <= n_py;
            r_visible <= n_visible;
            r_done    <= r_set.done;
            r_last    <= w_set_last;
        end
    end

    assign o_vld     = r_out_vld;
    assign o_px      = r_px;
    assign o_py      = r_py;
    assign o_visible = r_visible;
    assign o_done    = r_done;
    assign o_last    = r_last;

endmodule

// ----- sv/midpoint_circle_rasterizer_top.sv -----
// Midpoint circle rasterizer.
// Input stream (s_axis_*): tuser selects start or step; tdata carries the
// centre and radius, read on a start transfer only. A start gives no result.
// Each step transfer gives the eight octant-mirrored points of the current
// offset pair as eight output transfers, tlast on the eighth, each with a
// visibility flag clipped against the canvas registers; once the arc is
// finished a step gives one done transfer instead.
// The first result of a step passes through the point set register and
// then the result register. Throughput: the output channel moves one
// result a cycle while it is not stalled; the next item is taken in the
// cycle the last point of the previous one enters the result register.
// A stalled output holds its result; the input stalls once a point set
// waits behind it. Reset clears the circle state (no circle in progress),
// empties both stages and sets both canvas registers to 4096.
// Canvas registers (APB): width at 0x0, height at 0x4.
module midpoint_circle_rasterizer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // apb register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mcr_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [mcr_pkg::APB_BITS-1:0]         pwdata,
    output logic [mcr_pkg::APB_BITS-1:0]         prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: center_x, center_y, radius, zero pad
    input  logic [mcr_pkg::S_DATA_BITS-1:0]      s_axis_tdata,
    // tuser: op
    input  logic                                 s_axis_tuser,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: pixel_x, pixel_y, zero pad
    output logic [mcr_pkg::M_DATA_BITS-1:0]      m_axis_tdata,
    // tuser: visible, done_res
    output logic [mcr_pkg::M_USER_BITS-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import mcr_pkg::*;

    logic [CANVAS_BITS-1:0]     r_canvas_w;
    logic [CANVAS_BITS-1:0]     r_canvas_h;
    logic [COORD_BITS-1:0]      r_cx;
    logic [COORD_BITS-1:0]      r_cy;
    logic signed [OFF_BITS-1:0] r_a;
    logic signed [OFF_BITS-1:0] r_b;
    logic signed [ERR_BITS-1:0] r_err;
    logic                       r_active;

    logic [COORD_BITS-1:0]      n_cx;
    logic [COORD_BITS-1:0]      n_cy;
    logic signed [OFF_BITS-1:0] n_a;
    logic signed [OFF_BITS-1:0] n_b;
    logic signed [ERR_BITS-1:0] n_err;
    logic                       n_active;

    logic                       w_cfg_wr;
    logic                       w_accept;
    logic                       w_ready;
    logic                       w_load;
    logic                       w_op;
    logic [COORD_BITS-1:0]      w_in_cx;
    logic [COORD_BITS-1:0]      w_in_cy;
    logic [COORD_BITS-1:0]      w_in_r;
    logic                       w_finished;
    t_point_set                 w_set;
    logic signed [OFF_BITS-1:0] w_b1;
    logic signed [OFF_BITS-1:0] w_a1;
    logic signed [ERR_BITS:0]   w_e0;
    logic signed [ERR_BITS:0]   w_e1;
    logic signed [ERR_BITS:0]   w_e2;
    logic signed [ERR_BITS:0]   w_b1_term;
    logic signed [ERR_BITS:0]   w_a1_term;
    logic signed [PIX_BITS-1:0] w_px;
    logic signed [PIX_BITS-1:0] w_py;
    logic                       w_visible;
    logic                       w_done;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= CANVAS_RESET;
            r_canvas_h <= CANVAS_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_CANVAS_W) begin
                r_canvas_w <= pwdata[CANVAS_BITS-1:0];
            end else begin
                r_canvas_h <= pwdata[CANVAS_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CANVAS_W) ? APB_BITS'(r_canvas_w)
                                               : APB_BITS'(r_canvas_h);

    // input transfer decode
    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;
    assign w_op          = s_axis_tuser;
    assign w_in_cx       = s_axis_tdata[COORD_BITS-1:0];
    assign w_in_cy       = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_in_r        = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_finished    = !r_active || (r_a < r_b);
    assign w_load        = w_accept && (w_op == OP_STEP);

    // the two midpoint error updates
    always_comb begin
        w_e0      = {r_err[ERR_BITS-1], r_err};
        w_b1      = r_b;
        w_e1      = w_e0;
        if (w_e0 <= 0) begin
            w_b1 = r_b + 1'b1;
        end
        w_b1_term = {{(ERR_BITS-OFF_BITS){w_b1[OFF_BITS-1]}}, w_b1, 1'b1};
        if (w_e0 <= 0) begin
            w_e1 = w_e0 + w_b1_term;
        end
        w_a1      = r_a;
        w_e2      = w_e1;
        if (w_e1 > 0) begin
            w_a1 = r_a - 1'b1;
        end
        w_a1_term = {{(ERR_BITS-OFF_BITS){w_a1[OFF_BITS-1]}}, w_a1, 1'b1};
        if (w_e1 > 0) begin
            w_e2 = w_e1 - w_a1_term;
        end
    end

    // circle state next value
    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_a      = r_a;
        n_b      = r_b;
        n_err    = r_err;
        n_active = r_active;
        if (w_accept) begin
            if (w_op == OP_START) begin
                n_cx     = w_in_cx;
                n_cy     = w_in_cy;
                n_a      = {1'b0, w_in_r};
                n_b      = '0;
                n_err    = '0;
                n_active = 1'b1;
            end else if (w_finished) begin
                n_active = 1'b0;
            end else begin
                n_a   = w_a1;
                n_b   = w_b1;
                n_err = w_e2[ERR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_err    <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_a      <= n_a;
            r_b      <= n_b;
            r_err    <= n_err;
            r_active <= n_active;
        end
    end

    // point set of this step, taken before the update
    always_comb begin
        w_set.done = w_finished;
        w_set.cx   = r_cx;
        w_set.cy   = r_cy;
        w_set.a    = r_a;
        w_set.b    = r_b;
    end

    mcr_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_set      (w_set),
        .o_ready    (w_ready),
        .i_canvas_w (r_canvas_w),
        .i_canvas_h (r_canvas_h),
        .o_vld      (m_axis_tvalid),
        .i_rdy      (m_axis_tready),
        .o_px       (w_px),
        .o_py       (w_py),
        .o_visible  (w_visible),
        .o_done     (w_done),
        .o_last     (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = M_DATA_BITS'({w_py, w_px});
    assign m_axis_tuser = {w_done, w_visible};

endmodule
